### hdl/mm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_pkg: shared types and constants
// Command word passed from the byte packer to the mixing unit, the mixing
// constants, the rotate helper and the sequencer states.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam int unsigned MM3_FIFO_DEPTH = 4;

  localparam logic [31:0] MM3_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MM3_C2  = 32'h1b873593;
  localparam logic [31:0] MM3_ADD = 32'he6546b64;
  localparam logic [31:0] MM3_F1  = 32'h85ebca6b;
  localparam logic [31:0] MM3_F2  = 32'hc2b2ae35;

  localparam logic [4:0] MM3_ROT_K = 5'd15;
  localparam logic [4:0] MM3_ROT_H = 5'd13;

  // blk_en: word is a full block to mix; fin_en: finalize after it
  // seed: seed of the message, loaded by the mixing unit when first is set
  typedef struct packed {
    logic        blk_en;
    logic        fin_en;
    logic        first;
    logic [31:0] seed;
    logic [31:0] word;
    logic [23:0] tail;
    logic [1:0]  phase;
    logic [31:0] count;
  } mm3_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_K1,
    BK_K2,
    BK_MIX,
    BK_F0,
    BK_F1,
    BK_OUT
  } mm3_state_t;

  // rotate left, r is a nonzero constant at every call
  function automatic logic [31:0] mm3_rotl(input logic [31:0] x, input logic [4:0] r);
    logic [5:0] rs;
    rs = 6'd32 - {1'b0, r};
    return (x << r) | (x >> rs);
  endfunction

endpackage
`default_nettype wire

### hdl/mm3_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3 channel interfaces
// Byte input channel and hash result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm3_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface mm3_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface
`default_nettype wire

### hdl/mm3_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_front: byte packer
// Packs bytes little-endian into blocks, counts message bytes and issues a
// command for every full block and for every message end.
// ----------------------------------------------------------------------------
module mm3_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [31:0]      seed,
  mm3_byte_if.sink              in_ch,
  input  wire logic             q_full,
  output logic                  q_push,
  output mm3_pkg::mm3_cmd_t     q_cmd
);
  import mm3_pkg::*;

  logic [23:0] partial_r, partial_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] count_r, count_nxt;
  logic        first_r, first_nxt;
  logic        open_r, open_nxt;
  logic [31:0] mseed_r, mseed_nxt;

  logic        xfer;
  logic        blk;
  logic [23:0] part_b;
  logic [1:0]  phase_b;
  logic [31:0] count_b;

  assign in_ch.ready = !q_full;
  assign xfer        = in_ch.valid && in_ch.ready;
  assign blk         = in_ch.has_byte && (phase_r == 2'd3);

  always_comb begin
    part_b  = partial_r;
    phase_b = phase_r;
    count_b = count_r;
    if (in_ch.has_byte) begin
      count_b = count_r + 32'd1;
      phase_b = phase_r + 2'd1;
      if (blk) begin
        part_b = '0;
      end else begin
        part_b = partial_r | (24'(in_ch.data_byte) << {phase_r, 3'b000});
      end
    end
  end

  always_comb begin
    q_cmd.blk_en = blk;
    q_cmd.fin_en = in_ch.last;
    q_cmd.first  = first_r;
    q_cmd.seed   = open_r ? mseed_r : seed;
    q_cmd.word   = {in_ch.data_byte, partial_r};
    q_cmd.tail   = part_b;
    q_cmd.phase  = phase_b;
    q_cmd.count  = count_b;
    q_push       = xfer && (blk || in_ch.last);
  end

  always_comb begin
    partial_nxt = partial_r;
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    first_nxt   = first_r;
    open_nxt    = open_r;
    mseed_nxt   = mseed_r;
    if (xfer && (in_ch.has_byte || in_ch.last)) begin
      if (in_ch.last) begin
        partial_nxt = '0;
        phase_nxt   = '0;
        count_nxt   = '0;
        first_nxt   = 1'b1;
        open_nxt    = 1'b0;
      end else begin
        partial_nxt = part_b;
        phase_nxt   = phase_b;
        count_nxt   = count_b;
        open_nxt    = 1'b1;
        if (!open_r) begin
          mseed_nxt = seed;
        end
        if (blk) begin
          first_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      phase_r   <= '0;
      count_r   <= '0;
      first_r   <= 1'b1;
      open_r    <= 1'b0;
      mseed_r   <= '0;
    end else begin
      partial_r <= partial_nxt;
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      first_r   <= first_nxt;
      open_r    <= open_nxt;
      mseed_r   <= mseed_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/mm3_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_cmd_fifo: command queue
// Small register FIFO between the byte packer and the mixing unit.
// ----------------------------------------------------------------------------
module mm3_cmd_fifo #(
  parameter int unsigned DEPTH = mm3_pkg::MM3_FIFO_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mm3_pkg::mm3_cmd_t push_cmd,
  input  wire logic              pop,
  output mm3_pkg::mm3_cmd_t      head_cmd,
  output logic                   full,
  output logic                   empty
);
  import mm3_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  mm3_cmd_t      mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### hdl/mm3_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_back: mixing unit
// Sequencer around one shared 32x32 multiplier: block scramble and mix,
// tail scramble, length fold and final avalanche, output register.
// ----------------------------------------------------------------------------
module mm3_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mm3_pkg::mm3_cmd_t head_cmd,
  input  wire logic              q_empty,
  output logic                   q_pop,
  mm3_hash_if.source             out_ch
);
  import mm3_pkg::*;

  mm3_state_t  state_r, state_nxt;
  mm3_cmd_t    cmd_r, cmd_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] mix, tail_k, fin_t;
  logic        out_free;
  logic        head_k1;

  assign prod     = mul_a * mul_b;
  assign out_free = !out_valid_r || out_ch.ready;
  assign head_k1  = head_cmd.blk_en || (head_cmd.phase != 2'd0);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = head_k1 ? BK_K1 : BK_F0;
        end
      end
      BK_K1: state_nxt = BK_K2;
      BK_K2: state_nxt = cmd_r.blk_en ? BK_MIX : BK_F0;
      BK_MIX: begin
        if (!cmd_r.fin_en) begin
          state_nxt = BK_IDLE;
        end else begin
          state_nxt = (cmd_r.phase != 2'd0) ? BK_K1 : BK_F0;
        end
      end
      BK_F0: state_nxt = BK_F1;
      BK_F1: state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    hash_nxt      = hash_r;
    acc_nxt       = acc_r;
    q_pop         = 1'b0;
    mul_a         = acc_r;
    mul_b         = MM3_C1;
    mix           = mm3_rotl(hash_r ^ acc_r, MM3_ROT_H);
    tail_k        = (cmd_r.phase != 2'd0) ? acc_r : '0;
    fin_t         = hash_r ^ tail_k ^ cmd_r.count;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hash_nxt  = out_hash_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = head_cmd;
          if (head_cmd.first) begin
            hash_nxt = head_cmd.seed;
          end
        end
      end
      BK_K1: begin
        mul_a   = cmd_r.blk_en ? cmd_r.word : {8'h00, cmd_r.tail};
        mul_b   = MM3_C1;
        acc_nxt = prod;
      end
      BK_K2: begin
        mul_a   = mm3_rotl(acc_r, MM3_ROT_K);
        mul_b   = MM3_C2;
        acc_nxt = prod;
      end
      BK_MIX: begin
        hash_nxt       = (mix << 2) + mix + MM3_ADD;
        cmd_nxt.blk_en = 1'b0;
      end
      BK_F0: begin
        mul_a   = fin_t ^ (fin_t >> 16);
        mul_b   = MM3_F1;
        acc_nxt = prod;
      end
      BK_F1: begin
        mul_a   = acc_r ^ (acc_r >> 13);
        mul_b   = MM3_F2;
        acc_nxt = prod;
      end
      BK_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = acc_r ^ (acc_r >> 16);
        end
      end
      default: begin
        cmd_nxt = cmd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    hash_r     <= hash_nxt;
    acc_r      <= acc_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule
`default_nettype wire

### hdl/murmur3_32_stream_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash: streaming MurmurHash3 x86 32-bit
// Bytes enter one per transfer, the transfer with last closes the message
// and one hash transfer follows. Input takes one byte per cycle as long as
// the command queue has room. The mixing unit shares one multiplier: a full
// block runs through IDLE, K1, K2 and MIX there, so a steady stream of one
// byte per cycle is held; a message end runs block or tail scramble, then
// avalanche, before the hash is registered at the output. The seed is taken
// at the first transfer of each message; a seed written mid-message applies
// from the next message on.
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash #(
  parameter int unsigned FIFO_DEPTH = mm3_pkg::MM3_FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  mm3_byte_if.sink         in_ch,
  mm3_hash_if.source       out_ch
);
  import mm3_pkg::*;

  logic [31:0] seed_r;
  mm3_cmd_t    push_cmd, head_cmd;
  logic        push, pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  mm3_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .seed   (seed_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (push),
    .q_cmd  (push_cmd)
  );

  mm3_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  mm3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
